[rtl/dosl_pkg.sv]
// Package with shared constants and types of the draw order sorted list.
`timescale 1ns / 1ps
package dosl_pkg;

  localparam int Depth  = 32;
  localparam int IdxW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  localparam int IdW    = 10;
  localparam int OrderW = 8;
  localparam int PosW   = 16;
  localparam int RidxW  = 5;
  localparam int OutCountW = 6;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_e;

  typedef struct packed {
    logic [IdW-1:0]           id;
    logic [OrderW-1:0]        order;
    logic signed [PosW-1:0]   x;
    logic signed [PosW-1:0]   y;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    logic     occupied;
    logic     at_end;
  } cell_ctrl_t;

endpackage

[rtl/dosl_cell.sv]
// One list cell: holds one entry and moves it along the row on insert and remove.
`timescale 1ns / 1ps
module dosl_cell (
  input  logic                clk_i,
  input  dosl_pkg::cell_ctrl_t ctrl_i,
  input  dosl_pkg::entry_t    new_i,
  input  dosl_pkg::entry_t    left_i,
  input  dosl_pkg::entry_t    right_i,
  input  logic                prefix_i,
  output logic                prefix_o,
  output dosl_pkg::entry_t    entry_o
);

  dosl_pkg::entry_t entry_q;
  dosl_pkg::entry_t entry_d;
  logic             ins_hit;
  logic             rem_hit;
  logic             hit;

  always_comb begin
    ins_hit = ctrl_i.at_end ||
              (ctrl_i.occupied && (entry_q.id != new_i.id) &&
               ((entry_q.order > new_i.order) ||
                ((entry_q.order == new_i.order) &&
                 ($signed(entry_q.x) >= $signed(new_i.x)) &&
                 ($signed(entry_q.y) >= $signed(new_i.y)))));
    rem_hit = ctrl_i.occupied && (entry_q.id == new_i.id);
    case (ctrl_i.op)
      dosl_pkg::CELL_INSERT: hit = ins_hit;
      dosl_pkg::CELL_REMOVE: hit = rem_hit;
      default:               hit = 1'b0;
    endcase
    prefix_o = prefix_i || hit;
  end

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      dosl_pkg::CELL_INSERT: begin
        if (prefix_i) begin
          entry_d = left_i;
        end else if (hit) begin
          entry_d = new_i;
        end
      end
      dosl_pkg::CELL_REMOVE: begin
        if (prefix_o) begin
          entry_d = right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[rtl/draw_order_sorted_list.sv]
// Top level of the draw order sorted list: request control, cell row and result register.
`timescale 1ns / 1ps
// The list keeps up to 32 sprite entries in a row of cells, ordered by draw order with an
// x and y tie-break, and every transfer on the input yields exactly one result transfer.
// Each request is registered, executed in the EXEC state and then presented in the result
// register; a remove stays in EXEC while any entry still carries the removed id, because
// the cell row closes one gap per cycle. One item is worked on at a time, and the next
// input transfer is taken once the result register is free or is being emptied in the
// same cycle.
// No clearing pass is needed after reset.
module draw_order_sorted_list (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 operation_i,
  input  logic [9:0]                 entity_id_i,
  input  logic [7:0]                 draw_order_i,
  input  logic signed [15:0]         pos_x_i,
  input  logic signed [15:0]         pos_y_i,
  input  logic [4:0]                 read_index_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [9:0]                 out_id_o,
  output logic [7:0]                 out_order_o,
  output logic signed [15:0]         out_x_o,
  output logic signed [15:0]         out_y_o,
  output logic                       read_valid_o,
  output logic [5:0]                 list_count_o,
  output logic                       list_empty_o,
  output logic                       insert_dropped_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  localparam int Depth  = dosl_pkg::Depth;
  localparam int CountW = dosl_pkg::CountW;
  localparam int IdxW   = dosl_pkg::IdxW;

  logic                       state_q, state_d;
  logic [CountW-1:0]          count_q, count_d;
  logic [1:0]                 req_op_q;
  dosl_pkg::entry_t           req_entry_q;
  logic [dosl_pkg::RidxW-1:0] req_ridx_q;

  logic                       out_valid_q, out_valid_d;
  dosl_pkg::entry_t           out_entry_q, out_entry_d;
  logic                       out_rvalid_q, out_rvalid_d;
  logic                       out_drop_q, out_drop_d;
  logic [CountW-1:0]          out_count_q, out_count_d;

  logic                       in_xfer;
  logic                       out_free;
  logic                       full;
  logic                       any_hit;
  logic                       read_ok;
  dosl_pkg::cell_op_e         cell_op;

  dosl_pkg::entry_t           cell_entry [Depth];
  logic [Depth:0]             prefix;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign full       = (count_q == CountW'(Depth));
  assign any_hit    = prefix[Depth];
  assign read_ok    = (32'(req_ridx_q) < 32'(count_q));

  always_comb begin
    cell_op = dosl_pkg::CELL_HOLD;
    if (state_q == S_EXEC) begin
      case (req_op_q)
        dosl_pkg::OP_INSERT: cell_op = full ? dosl_pkg::CELL_HOLD : dosl_pkg::CELL_INSERT;
        dosl_pkg::OP_REMOVE: cell_op = dosl_pkg::CELL_REMOVE;
        default:             cell_op = dosl_pkg::CELL_HOLD;
      endcase
    end
  end

  assign prefix[0] = 1'b0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    dosl_pkg::cell_ctrl_t ctrl;
    dosl_pkg::entry_t     left;
    dosl_pkg::entry_t     right;

    assign ctrl.op       = cell_op;
    assign ctrl.occupied = (CountW'(i) < count_q);
    assign ctrl.at_end   = (CountW'(i) == count_q);

    if (i == 0) begin : g_first
      assign left = req_entry_q;
    end else begin : g_mid
      assign left = cell_entry[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right = req_entry_q;
    end else begin : g_inner
      assign right = cell_entry[i+1];
    end

    dosl_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .new_i    (req_entry_q),
      .left_i   (left),
      .right_i  (right),
      .prefix_i (prefix[i]),
      .prefix_o (prefix[i+1]),
      .entry_o  (cell_entry[i])
    );
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_entry_d  = out_entry_q;
    out_rvalid_d = out_rvalid_q;
    out_drop_d   = out_drop_q;
    out_count_d  = out_count_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        out_entry_d  = '0;
        out_rvalid_d = 1'b0;
        out_drop_d   = 1'b0;
        unique case (req_op_q)
          dosl_pkg::OP_INSERT: begin
            if (full) begin
              out_drop_d = 1'b1;
            end else begin
              count_d = count_q + CountW'(1);
            end
          end
          dosl_pkg::OP_REMOVE: begin
            if (any_hit) begin
              count_d = count_q - CountW'(1);
            end
          end
          dosl_pkg::OP_CLEAR: begin
            count_d = '0;
          end
          dosl_pkg::OP_READ: begin
            if (read_ok) begin
              out_entry_d  = cell_entry[IdxW'(req_ridx_q)];
              out_rvalid_d = 1'b1;
            end
          end
          default: begin
            count_d = count_q;
          end
        endcase
        out_count_d = count_d;
        if (!((req_op_q == dosl_pkg::OP_REMOVE) && any_hit)) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_op_q          <= operation_i;
      req_entry_q.id    <= entity_id_i;
      req_entry_q.order <= draw_order_i;
      req_entry_q.x     <= pos_x_i;
      req_entry_q.y     <= pos_y_i;
      req_ridx_q        <= read_index_i;
    end
    out_entry_q  <= out_entry_d;
    out_rvalid_q <= out_rvalid_d;
    out_drop_q   <= out_drop_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o      = out_valid_q;
  assign out_id_o         = out_entry_q.id;
  assign out_order_o      = out_entry_q.order;
  assign out_x_o          = out_entry_q.x;
  assign out_y_o          = out_entry_q.y;
  assign read_valid_o     = out_rvalid_q;
  assign list_count_o     = dosl_pkg::OutCountW'(out_count_q);
  assign list_empty_o     = (out_count_q == '0);
  assign insert_dropped_o = out_drop_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Depth))
    else $error("entry count exceeds list depth");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_EXEC))
    else $error("accepted request not executed");

  a_exec_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> !out_valid_q)
    else $error("result register busy while executing");

  a_drop_not_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_drop_q && out_rvalid_q))
    else $error("dropped insert reported as valid read");

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (state_q == S_IDLE)) |-> (out_count_q == count_q))
    else $error("reported count differs from list count");
`endif

endmodule

[sim/testbench.sv]
// Self-checking testbench of the draw order sorted list: directed table, random traffic, shadow list.
`timescale 1ns / 1ps
module testbench;

  localparam int RandomItems = 1750;
  localparam int StallLimit  = 5000;
  localparam int HoldAfter   = 400;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 60;

  typedef struct packed {
    logic [1:0]         op;
    logic [9:0]         id;
    logic [7:0]         order;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [4:0]         ridx;
  } list_req_t;

  typedef struct packed {
    logic [9:0]         rd_id;
    logic [7:0]         rd_order;
    logic signed [15:0] rd_x;
    logic signed [15:0] rd_y;
    logic               rd_valid;
    logic [5:0]         count;
    logic               empty;
    logic               dropped;
  } list_result_t;

  typedef struct packed {
    logic         fixed;
    list_req_t    req;
    list_result_t want;
  } directed_row_t;

  typedef enum {TRAFFIC_FILL, TRAFFIC_MIX, TRAFFIC_DRAIN} traffic_e;

  localparam list_result_t NO_CHECK   = '0;
  localparam list_result_t EMPTY_LIST =
    '{10'd0, 8'd0, 16'sd0, 16'sd0, 1'b0, 6'd0, 1'b1, 1'b0};

  localparam directed_row_t DIRECTED_ROWS [22] = '{
    '{1'b1, '{dosl_pkg::OP_READ, 10'd0, 8'd0, 16'sd0, 16'sd0, 5'd0}, EMPTY_LIST},
    '{1'b1, '{dosl_pkg::OP_CLEAR, 10'd1023, 8'd255, 16'h7fff, 16'h8000, 5'd31}, EMPTY_LIST},
    '{1'b1, '{dosl_pkg::OP_REMOVE, 10'd5, 8'd0, 16'sd0, 16'sd0, 5'd0}, EMPTY_LIST},
    '{1'b1, '{dosl_pkg::OP_INSERT, 10'd1023, 8'd255, 16'h7fff, 16'h7fff, 5'd0},
      '{10'd0, 8'd0, 16'sd0, 16'sd0, 1'b0, 6'd1, 1'b0, 1'b0}},
    '{1'b1, '{dosl_pkg::OP_READ, 10'd0, 8'd0, 16'sd0, 16'sd0, 5'd0},
      '{10'd1023, 8'd255, 16'h7fff, 16'h7fff, 1'b1, 6'd1, 1'b0, 1'b0}},
    '{1'b1, '{dosl_pkg::OP_INSERT, 10'd0, 8'd0, 16'h8000, 16'h8000, 5'd0},
      '{10'd0, 8'd0, 16'sd0, 16'sd0, 1'b0, 6'd2, 1'b0, 1'b0}},
    '{1'b1, '{dosl_pkg::OP_READ, 10'd0, 8'd0, 16'sd0, 16'sd0, 5'd0},
      '{10'd0, 8'd0, 16'h8000, 16'h8000, 1'b1, 6'd2, 1'b0, 1'b0}},
    '{1'b1, '{dosl_pkg::OP_READ, 10'd0, 8'd0, 16'sd0, 16'sd0, 5'd31},
      '{10'd0, 8'd0, 16'sd0, 16'sd0, 1'b0, 6'd2, 1'b0, 1'b0}},
    '{1'b0, '{dosl_pkg::OP_INSERT, 10'd7, 8'd0, 16'sd0, 16'sd0, 5'd0}, NO_CHECK},
    '{1'b0, '{dosl_pkg::OP_INSERT, 10'd8, 8'd0, -16'sd5, -16'sd5, 5'd0}, NO_CHECK},
    '{1'b0, '{dosl_pkg::OP_INSERT, 10'd8, 8'd0, -16'sd6, -16'sd6, 5'd0}, NO_CHECK},
    '{1'b0, '{dosl_pkg::OP_INSERT, 10'd9, 8'd0, 16'sd5, -16'sd100, 5'd0}, NO_CHECK},
    '{1'b0, '{dosl_pkg::OP_INSERT, 10'd3, 8'd0, 16'sd0, 16'sd0, 5'd0}, NO_CHECK},
    '{1'b0, '{dosl_pkg::OP_READ, 10'd0, 8'd0, 16'sd0, 16'sd0, 5'd2}, NO_CHECK},
    '{1'b0, '{dosl_pkg::OP_READ, 10'd0, 8'd0, 16'sd0, 16'sd0, 5'd4}, NO_CHECK},
    '{1'b0, '{dosl_pkg::OP_REMOVE, 10'd8, 8'd0, 16'sd0, 16'sd0, 5'd0}, NO_CHECK},
    '{1'b0, '{dosl_pkg::OP_READ, 10'd0, 8'd0, 16'sd0, 16'sd0, 5'd1}, NO_CHECK},
    '{1'b0, '{dosl_pkg::OP_REMOVE, 10'd1023, 8'd0, 16'sd0, 16'sd0, 5'd0}, NO_CHECK},
    '{1'b0, '{dosl_pkg::OP_READ, 10'd0, 8'd0, 16'sd0, 16'sd0, 5'd5}, NO_CHECK},
    '{1'b1, '{dosl_pkg::OP_CLEAR, 10'd0, 8'd0, 16'sd0, 16'sd0, 5'd0}, EMPTY_LIST},
    '{1'b0, '{dosl_pkg::OP_INSERT, 10'd512, 8'd128, 16'sd1, -16'sd1, 5'd16}, NO_CHECK},
    '{1'b1, '{dosl_pkg::OP_REMOVE, 10'd512, 8'd0, 16'sd0, 16'sd0, 5'd0}, EMPTY_LIST}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         operation = dosl_pkg::OP_READ;
  logic [9:0]         entity_id = '0;
  logic [7:0]         draw_order = '0;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic [4:0]         read_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [9:0]         out_id;
  logic [7:0]         out_order;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic               read_valid;
  logic [5:0]         list_count;
  logic               list_empty;
  logic               insert_dropped;

  dosl_pkg::entry_t shadow_slots [dosl_pkg::Depth];
  int unsigned      shadow_count = 0;
  list_result_t     expected_results [$];
  int               mismatch_count = 0;
  int               sender_calm = 0;
  int               receiver_calm = 0;

  draw_order_sorted_list dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .operation_i     (operation),
    .entity_id_i     (entity_id),
    .draw_order_i    (draw_order),
    .pos_x_i         (pos_x),
    .pos_y_i         (pos_y),
    .read_index_i    (read_index),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .out_id_o        (out_id),
    .out_order_o     (out_order),
    .out_x_o         (out_x),
    .out_y_o         (out_y),
    .read_valid_o    (read_valid),
    .list_count_o    (list_count),
    .list_empty_o    (list_empty),
    .insert_dropped_o(insert_dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic list_result_t predict_list_op(input list_req_t req);
    list_result_t res;
    int unsigned  pos;
    int unsigned  kept;
    res = '0;
    if (req.op == dosl_pkg::OP_INSERT) begin
      if (shadow_count >= dosl_pkg::Depth) begin
        res.dropped = 1'b1;
      end else begin
        pos = shadow_count;
        for (int i = int'(shadow_count) - 1; i >= 0; i--) begin
          if (shadow_slots[i].id != req.id &&
              (shadow_slots[i].order > req.order ||
               (shadow_slots[i].order == req.order &&
                $signed(shadow_slots[i].x) >= $signed(req.x) &&
                $signed(shadow_slots[i].y) >= $signed(req.y)))) begin
            pos = i;
          end
        end
        for (int i = int'(shadow_count); i > int'(pos); i--) begin
          shadow_slots[i] = shadow_slots[i-1];
        end
        shadow_slots[pos] = '{req.id, req.order, req.x, req.y};
        shadow_count++;
      end
    end else if (req.op == dosl_pkg::OP_REMOVE) begin
      kept = 0;
      for (int i = 0; i < int'(shadow_count); i++) begin
        if (shadow_slots[i].id != req.id) begin
          shadow_slots[kept] = shadow_slots[i];
          kept++;
        end
      end
      shadow_count = kept;
    end else if (req.op == dosl_pkg::OP_CLEAR) begin
      shadow_count = 0;
    end else if (req.ridx < shadow_count) begin
      res.rd_id    = shadow_slots[req.ridx].id;
      res.rd_order = shadow_slots[req.ridx].order;
      res.rd_x     = shadow_slots[req.ridx].x;
      res.rd_y     = shadow_slots[req.ridx].y;
      res.rd_valid = 1'b1;
    end
    res.count = 6'(shadow_count);
    res.empty = (shadow_count == 0);
    return res;
  endfunction

  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic list_req_t random_request(input traffic_e mode);
    list_req_t req;
    int        pick;
    pick      = $urandom_range(0, 99);
    req.id    = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
    req.order = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    req.x     = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4) - 2);
    req.y     = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4) - 2);
    req.ridx  = ($urandom_range(0, 3) == 0) ? 5'($urandom)
                                            : 5'($urandom_range(0, shadow_count));
    case (mode)
      TRAFFIC_FILL: begin
        req.op = (pick < 85) ? dosl_pkg::OP_INSERT : dosl_pkg::OP_READ;
      end
      TRAFFIC_MIX: begin
        if (pick < 40) req.op = dosl_pkg::OP_INSERT;
        else if (pick < 60) req.op = dosl_pkg::OP_REMOVE;
        else if (pick < 95) req.op = dosl_pkg::OP_READ;
        else req.op = dosl_pkg::OP_CLEAR;
      end
      default: begin
        if (pick < 10) req.op = dosl_pkg::OP_INSERT;
        else if (pick < 60) req.op = dosl_pkg::OP_REMOVE;
        else req.op = dosl_pkg::OP_READ;
      end
    endcase
    if (req.op == dosl_pkg::OP_REMOVE && shadow_count > 0 && $urandom_range(0, 1) == 0) begin
      req.id = shadow_slots[$urandom_range(0, shadow_count - 1)].id;
    end
    return req;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input longint got, input longint want);
    if (got != want) begin
      report_mismatch($sformatf("%s mismatch: got %0d, expected %0d", what, got, want));
    end
  endtask

  task automatic send_request(input list_req_t req, input logic fixed,
                              input list_result_t want);
    int           wait_cycles;
    list_result_t queued;
    wait_cycles = draw_wait(sender_calm);
    if (wait_cycles > 0) begin
      in_valid <= 1'b0;
      repeat (wait_cycles) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= req.op;
    entity_id  <= req.id;
    draw_order <= req.order;
    pos_x      <= req.x;
    pos_y      <= req.y;
    read_index <= req.ridx;
    do @(posedge clk); while (!in_ready);
    if (fixed) begin
      void'(predict_list_op(req));
      queued = want;
    end else begin
      queued = predict_list_op(req);
    end
    expected_results = {expected_results, queued};
  endtask

  initial begin : stimulus
    traffic_e mode;
    int       phase_left;
    mode = TRAFFIC_FILL;
    phase_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);
    end
    for (int n = 0; n < RandomItems; n++) begin
      if (phase_left == 0) begin
        mode = traffic_e'($urandom_range(0, 2));
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      send_request(random_request(mode), 1'b0, NO_CHECK);
    end
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** draw_order_sorted_list: PASSED **");
    end else begin
      $display("** draw_order_sorted_list: FAILED **");
    end
    $finish;
  end

  initial begin : result_sink
    list_result_t got;
    list_result_t want;
    int           results_seen;
    int           wait_cycles;
    results_seen = 0;
    wait (rst_n);
    forever begin
      // One long hold-off lets the list back up until the input stalls.
      if (results_seen == HoldAfter) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      wait_cycles = draw_wait(receiver_calm);
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = '{out_id, out_order, out_x, out_y, read_valid, list_count, list_empty,
              insert_dropped};
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result transfer with no request pending");
      end else begin
        want = expected_results.pop_front();
        check_field("out_id", got.rd_id, want.rd_id);
        check_field("out_order", got.rd_order, want.rd_order);
        check_field("out_x", got.rd_x, want.rd_x);
        check_field("out_y", got.rd_y, want.rd_y);
        check_field("read_valid", got.rd_valid, want.rd_valid);
        check_field("list_count", got.count, want.count);
        check_field("list_empty", got.empty, want.empty);
        check_field("insert_dropped", got.dropped, want.dropped);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    wait (rst_n);
    while (quiet_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("** draw_order_sorted_list: FAILED **");
    $finish;
  end

endmodule
